### hw/rtl/pof_pkg.sv
package pof_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_RANGES_DEF = 16;
    localparam int PART_BITS_DEF  = 8;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int SLOT_FW  = 4;
    localparam int IDX_W    = 32;
    localparam int OWNER_FW = 8;
    localparam int LPART_W  = 8;
    localparam int RCNT_W   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int TOTAL_W  = 32;

    // Stream payload widths (padded to whole bytes)
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 136;

    // Request opcodes
    typedef enum logic [OP_W-1:0] {
        OP_LOAD_ROW = 2'd0,
        OP_LOAD_COL = 2'd1,
        OP_CLASSIFY = 2'd2,
        OP_CLEAR    = 2'd3
    } opcode_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_PART  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd2;

    // Result of one pass through the shared compare unit
    typedef struct packed {
        logic hit;
        logic remote;
    } match_t;

endpackage

### hw/rtl/partition_owner_filter_core.sv
// Load and clear requests take effect at the accepting edge, one a cycle when idle.
// A classify request scans the row table, then the column table, one slot a cycle
// through the single bound comparator, and stops a side at its first hit or after
// its last valid slot. ST_DONE then waits for a free output register and registers
// the result and m_tvalid; no request is taken until the block is back in ST_IDLE.
// Reset clears control state, totals, own part; counts go to one; tables are kept.
module partition_owner_filter_core #(
    parameter int MAX_RANGES = pof_pkg::MAX_RANGES_DEF,
    parameter int PART_BITS  = pof_pkg::PART_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // entry_slot[3:0], end_bound[35:4], owner_part[43:36],
    // row_index[75:44], col_index[107:76], zero pad
    input  logic [pof_pkg::S_TDATA_W-1:0]   s_tdata,
    // opcode[1:0]
    input  logic [pof_pkg::OP_W-1:0]        s_tuser,
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // row_is_remote[0], col_is_remote[1], remote_row_index[33:2],
    // remote_col_index[65:34], out_of_range[66], remote_row_count[98:67],
    // remote_col_count[130:99], zero pad
    output logic [pof_pkg::M_TDATA_W-1:0]   m_tdata,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [pof_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [pof_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import pof_pkg::*;

    localparam int SLOT_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W  = $clog2(MAX_RANGES + 1);
    localparam int ADDR_W = SLOT_W + 1;
    localparam int DEPTH  = 2 ** ADDR_W;
    localparam int DATA_W = IDX_W + PART_BITS;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic                  side_reg, side_next;
    logic [CNT_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]      row_idx_reg, row_idx_next;
    logic [IDX_W-1:0]      col_idx_reg, col_idx_next;
    logic                  row_found_reg, row_found_next;
    logic                  row_rem_reg, row_rem_next;
    logic                  col_found_reg, col_found_next;
    logic                  col_rem_reg, col_rem_next;
    logic [TOTAL_W-1:0]    row_tot_reg, row_tot_next;
    logic [TOTAL_W-1:0]    col_tot_reg, col_tot_next;
    logic [LPART_W-1:0]    own_part_reg;
    logic [RCNT_W-1:0]     row_cnt_reg;
    logic [RCNT_W-1:0]     col_cnt_reg;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    // Request fields
    opcode_t               in_op;
    logic [SLOT_FW-1:0]    in_slot;
    logic [IDX_W-1:0]      in_bound;
    logic [OWNER_FW-1:0]   in_owner;
    logic [IDX_W-1:0]      in_row;
    logic [IDX_W-1:0]      in_col;
    logic                  accept;

    logic                  slot_ok;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [DATA_W-1:0]     ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [DATA_W-1:0]     ram_rdata;

    logic [CNT_W-1:0]      row_n;
    logic [CNT_W-1:0]      col_n;
    logic [CNT_W-1:0]      side_n;
    logic [IDX_W-1:0]      side_idx;
    match_t                match;
    logic                  side_miss;

    logic [TOTAL_W-1:0]    row_tot_new;
    logic [TOTAL_W-1:0]    col_tot_new;
    logic                  oor;

    // Unpack request
    assign in_op    = opcode_t'(s_tuser);
    assign in_slot  = s_tdata[3:0];
    assign in_bound = s_tdata[35:4];
    assign in_owner = s_tdata[43:36];
    assign in_row   = s_tdata[75:44];
    assign in_col   = s_tdata[107:76];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Table writes: row table in the lower half, column table in the upper
    assign slot_ok   = (32'(in_slot) < 32'(MAX_RANGES));
    assign ram_we    = accept && slot_ok &&
                       ((in_op == OP_LOAD_ROW) || (in_op == OP_LOAD_COL));
    assign ram_waddr = {(in_op == OP_LOAD_COL), SLOT_W'(in_slot)};
    assign ram_wdata = {PART_BITS'(in_owner), in_bound};
    assign ram_raddr = {side_reg, rd_idx_reg[SLOT_W-1:0]};

    pof_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_tables (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Clamp range counts to the table depth
    assign row_n = (32'(row_cnt_reg) > 32'(MAX_RANGES)) ? CNT_W'(MAX_RANGES)
                                                         : CNT_W'(row_cnt_reg);
    assign col_n = (32'(col_cnt_reg) > 32'(MAX_RANGES)) ? CNT_W'(MAX_RANGES)
                                                         : CNT_W'(col_cnt_reg);
    assign side_n   = side_reg ? col_n : row_n;
    assign side_idx = side_reg ? col_idx_reg : row_idx_reg;

    pof_match_unit #(
        .PART_BITS (PART_BITS)
    ) u_match (
        .cmp_en   (rd_pend_reg),
        .bound    (ram_rdata[IDX_W-1:0]),
        .index    (side_idx),
        .owner    (ram_rdata[DATA_W-1:IDX_W]),
        .own_part (PART_BITS'(own_part_reg)),
        .result   (match)
    );

    // No hit and nothing left to read on this side
    assign side_miss = !match.hit && (rd_idx_reg >= side_n);

    // Saturating totals and result word
    assign row_tot_new = (row_rem_reg && (row_tot_reg != '1)) ? row_tot_reg + 32'd1
                                                               : row_tot_reg;
    assign col_tot_new = (col_rem_reg && (col_tot_reg != '1)) ? col_tot_reg + 32'd1
                                                               : col_tot_reg;
    assign oor = !row_found_reg || !col_found_reg;

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        side_next      = side_reg;
        rd_idx_next    = rd_idx_reg;
        rd_pend_next   = 1'b0;
        row_idx_next   = row_idx_reg;
        col_idx_next   = col_idx_reg;
        row_found_next = row_found_reg;
        row_rem_next   = row_rem_reg;
        col_found_next = col_found_reg;
        col_rem_next   = col_rem_reg;
        row_tot_next   = row_tot_reg;
        col_tot_next   = col_tot_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_op)
                        OP_CLASSIFY: begin
                            row_idx_next = in_row;
                            col_idx_next = in_col;
                            side_next    = 1'b0;
                            rd_idx_next  = '0;
                            state_next   = ST_SCAN;
                        end
                        OP_CLEAR: begin
                            row_tot_next = '0;
                            col_tot_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (match.hit || side_miss) begin
                    // Close this side, then move on or finish
                    if (!side_reg) begin
                        row_found_next = match.hit;
                        row_rem_next   = match.hit && match.remote;
                        side_next      = 1'b1;
                        rd_idx_next    = '0;
                    end else begin
                        col_found_next = match.hit;
                        col_rem_next   = match.hit && match.remote;
                        state_next     = ST_DONE;
                    end
                end else begin
                    // Issue the next slot read
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                    rd_pend_next = 1'b1;
                end
            end
            ST_DONE: begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    row_tot_next  = row_tot_new;
                    col_tot_next  = col_tot_new;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, col_tot_new, row_tot_new, oor,
                                     col_rem_reg ? col_idx_reg : 32'd0,
                                     row_rem_reg ? row_idx_reg : 32'd0,
                                     col_rem_reg, row_rem_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            row_tot_reg  <= '0;
            col_tot_reg  <= '0;
            own_part_reg <= '0;
            row_cnt_reg  <= RCNT_W'(1);
            col_cnt_reg  <= RCNT_W'(1);
        end else begin
            state_reg    <= state_next;
            rd_pend_reg  <= rd_pend_next;
            m_tvalid_reg <= m_tvalid_next;
            row_tot_reg  <= row_tot_next;
            col_tot_reg  <= col_tot_next;
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_OWN_PART:  own_part_reg <= cfg_wdata;
                    CFG_ROW_COUNT: row_cnt_reg  <= cfg_wdata[RCNT_W-1:0];
                    CFG_COL_COUNT: col_cnt_reg  <= cfg_wdata[RCNT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        side_reg      <= side_next;
        rd_idx_reg    <= rd_idx_next;
        row_idx_reg   <= row_idx_next;
        col_idx_reg   <= col_idx_next;
        row_found_reg <= row_found_next;
        row_rem_reg   <= row_rem_next;
        col_found_reg <= col_found_next;
        col_rem_reg   <= col_rem_next;
        m_tdata_reg   <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### hw/rtl/pof_ram.sv
module pof_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/pof_match_unit.sv
module pof_match_unit #(
    parameter int PART_BITS = pof_pkg::PART_BITS_DEF
) (
    input  logic                       cmp_en,
    input  logic [pof_pkg::IDX_W-1:0]  bound,
    input  logic [pof_pkg::IDX_W-1:0]  index,
    input  logic [PART_BITS-1:0]       owner,
    input  logic [PART_BITS-1:0]       own_part,
    output pof_pkg::match_t            result
);

    import pof_pkg::*;

    // Slot qualifies when its exclusive bound lies above the index
    always_comb begin
        result.hit    = cmp_en && (bound > index);
        result.remote = (owner != own_part);
    end

endmodule

### tb/tb_partition_owner_filter_core.sv
module tb_partition_owner_filter_core;
    timeunit 1ns;
    timeprecision 1ps;

    import pof_pkg::*;

    localparam int SLOTS = MAX_RANGES_DEF;
    // Longest scan: both tables missed, plus the result register
    localparam int SCAN_SLACK = 2 * SLOTS + 8;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int PHASES = 8;
    localparam int RANDOM_PER_PHASE = 225;

    // Expected outcome of one classify request
    typedef struct {
        logic             row_rem;
        logic             col_rem;
        logic [IDX_W-1:0] row_idx;
        logic [IDX_W-1:0] col_idx;
        logic             oor;
        logic [TOTAL_W-1:0] row_cnt;
        logic [TOTAL_W-1:0] col_cnt;
    } verdict_t;

    // Mirror of the ownership tables and totals, plus the verdicts still owed
    class ownership_checker;
        logic [LPART_W-1:0]  own_part;
        logic [RCNT_W-1:0]   row_count;
        logic [RCNT_W-1:0]   col_count;
        logic [IDX_W-1:0]    row_bound [SLOTS];
        logic [IDX_W-1:0]    col_bound [SLOTS];
        logic [OWNER_FW-1:0] row_owner [SLOTS];
        logic [OWNER_FW-1:0] col_owner [SLOTS];
        bit                  row_written [SLOTS];
        bit                  col_written [SLOTS];
        logic [TOTAL_W-1:0]  row_total;
        logic [TOTAL_W-1:0]  col_total;
        verdict_t            pending_verdicts [$];
        int                  errors;

        function new();
            own_part   = '0;
            row_count  = 5'd1;
            col_count  = 5'd1;
            row_total  = '0;
            col_total  = '0;
            errors     = 0;
            foreach (row_written[k]) begin
                row_written[k] = 1'b0;
                col_written[k] = 1'b0;
            end
        endfunction

        function int unsigned live_slots(logic [RCNT_W-1:0] c);
            return (c > SLOTS) ? SLOTS : c;
        endfunction

        function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_OWN_PART:  own_part  = val;
                CFG_ROW_COUNT: row_count = val[RCNT_W-1:0];
                CFG_COL_COUNT: col_count = val[RCNT_W-1:0];
                default: ;
            endcase
        endfunction

        // First live slot whose bound lies above the index owns it
        function void find_owner(bit is_row, logic [IDX_W-1:0] idx,
                                 output bit found, output logic [OWNER_FW-1:0] owner);
            int unsigned n;
            n = live_slots(is_row ? row_count : col_count);
            found = 1'b0;
            owner = '0;
            for (int k = 0; k < n; k++) begin
                if (!found && (is_row ? row_bound[k] : col_bound[k]) > idx) begin
                    found = 1'b1;
                    owner = is_row ? row_owner[k] : col_owner[k];
                end
            end
        endfunction

        function void note_request(opcode_t op, logic [SLOT_FW-1:0] slot,
                                   logic [IDX_W-1:0] bound, logic [OWNER_FW-1:0] owner,
                                   logic [IDX_W-1:0] ri, logic [IDX_W-1:0] ci);
            bit r_found, c_found;
            logic [OWNER_FW-1:0] r_own, c_own;
            verdict_t v;
            case (op)
                OP_LOAD_ROW: begin
                    row_bound[slot] = bound;
                    row_owner[slot] = owner;
                    row_written[slot] = 1'b1;
                end
                OP_LOAD_COL: begin
                    col_bound[slot] = bound;
                    col_owner[slot] = owner;
                    col_written[slot] = 1'b1;
                end
                OP_CLEAR: begin
                    row_total = '0;
                    col_total = '0;
                end
                default: begin
                    find_owner(1'b1, ri, r_found, r_own);
                    find_owner(1'b0, ci, c_found, c_own);
                    v.row_rem = r_found && (r_own != own_part);
                    v.col_rem = c_found && (c_own != own_part);
                    // Saturate the running totals
                    if (v.row_rem && row_total != '1)
                        row_total = row_total + 1;
                    if (v.col_rem && col_total != '1)
                        col_total = col_total + 1;
                    v.row_idx = v.row_rem ? ri : '0;
                    v.col_idx = v.col_rem ? ci : '0;
                    v.oor     = !r_found || !c_found;
                    v.row_cnt = row_total;
                    v.col_cnt = col_total;
                    pending_verdicts.push_back(v);
                end
            endcase
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [M_TDATA_W-1:0] d);
            verdict_t v;
            if (pending_verdicts.size() == 0) begin
                report($sformatf("result with nothing pending, data %h", d));
            end else begin
                v = pending_verdicts.pop_front();
                if (d[0] !== v.row_rem)
                    report($sformatf("row_is_remote got %b exp %b", d[0], v.row_rem));
                if (d[1] !== v.col_rem)
                    report($sformatf("col_is_remote got %b exp %b", d[1], v.col_rem));
                if (d[33:2] !== v.row_idx)
                    report($sformatf("remote_row_index got %h exp %h", d[33:2], v.row_idx));
                if (d[65:34] !== v.col_idx)
                    report($sformatf("remote_col_index got %h exp %h", d[65:34], v.col_idx));
                if (d[66] !== v.oor)
                    report($sformatf("out_of_range got %b exp %b", d[66], v.oor));
                if (d[98:67] !== v.row_cnt)
                    report($sformatf("remote_row_count got %h exp %h", d[98:67], v.row_cnt));
                if (d[130:99] !== v.col_cnt)
                    report($sformatf("remote_col_count got %h exp %h", d[130:99], v.col_cnt));
            end
        endtask
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    ownership_checker chk;
    int src_gap_pct = 0;
    int sink_stall_pct = 0;
    int unsigned stall_left = 0;

    partition_owner_filter_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Stall the result channel in random bursts
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
            stall_left <= $urandom_range(0, 16);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Check every accepted result
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            chk.check_result(m_tdata);
    end

    function automatic logic [OWNER_FW-1:0] pick_owner();
        case ($urandom_range(0, 4))
            0: return chk.own_part;
            1: return chk.own_part ^ 8'h01;
            2: return 8'h00;
            3: return 8'hFF;
            default: return OWNER_FW'($urandom);
        endcase
    endfunction

    // Favour indices on and around the live bounds
    function automatic logic [IDX_W-1:0] pick_index(bit is_row);
        int unsigned n, r, k;
        logic [IDX_W-1:0] b;
        n = chk.live_slots(is_row ? chk.row_count : chk.col_count);
        r = $urandom_range(0, 99);
        if (n == 0 || r < 10)
            return $urandom;
        if (r < 16)
            return $urandom_range(0, 1) ? '1 : '0;
        k = $urandom_range(0, n - 1);
        b = is_row ? chk.row_bound[k] : chk.col_bound[k];
        case ($urandom_range(0, 4))
            0: return b - 1;
            1: return b;
            2: return b + 1;
            default: return $urandom_range(b, 0);
        endcase
    endfunction

    task automatic send_request(opcode_t op, logic [SLOT_FW-1:0] slot,
                                logic [IDX_W-1:0] bound, logic [OWNER_FW-1:0] owner,
                                logic [IDX_W-1:0] ri, logic [IDX_W-1:0] ci);
        int unsigned gap;
        // Idle the request channel for a random burst
        if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, ci, ri, owner, bound, slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        chk.note_request(op, slot, bound, owner, ri, ci);
    endtask

    task automatic send_load(bit is_row, logic [SLOT_FW-1:0] slot,
                             logic [IDX_W-1:0] bound, logic [OWNER_FW-1:0] owner);
        send_request(is_row ? OP_LOAD_ROW : OP_LOAD_COL, slot, bound, owner,
                     $urandom, $urandom);
    endtask

    // Load any live slot not yet written, so no scan reads a blank entry
    task automatic fill_unwritten();
        int unsigned nr, nc;
        nr = chk.live_slots(chk.row_count);
        nc = chk.live_slots(chk.col_count);
        for (int k = 0; k < nr; k++)
            if (!chk.row_written[k])
                send_load(1'b1, SLOT_FW'(k), $urandom, pick_owner());
        for (int k = 0; k < nc; k++)
            if (!chk.col_written[k])
                send_load(1'b0, SLOT_FW'(k), $urandom, pick_owner());
    endtask

    task automatic send_classify(logic [IDX_W-1:0] ri, logic [IDX_W-1:0] ci);
        fill_unwritten();
        send_request(OP_CLASSIFY, SLOT_FW'($urandom), $urandom, OWNER_FW'($urandom),
                     ri, ci);
    endtask

    task automatic send_clear();
        send_request(OP_CLEAR, SLOT_FW'($urandom), $urandom, OWNER_FW'($urandom),
                     $urandom, $urandom);
    endtask

    // Hold off requests until every verdict is in and the scan has settled
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (chk.pending_verdicts.size() != 0) @(posedge aclk);
        repeat (SCAN_SLACK) @(posedge aclk);
    endtask

    task automatic set_config(logic [LPART_W-1:0] lp, logic [RCNT_W-1:0] rc,
                              logic [RCNT_W-1:0] cc, bit poke_unused);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_OWN_PART;
        cfg_wdata <= lp;
        @(posedge aclk);
        chk.apply_config(CFG_OWN_PART, lp);
        cfg_addr  <= CFG_ROW_COUNT;
        cfg_wdata <= {3'b0, rc};
        @(posedge aclk);
        chk.apply_config(CFG_ROW_COUNT, {3'b0, rc});
        cfg_addr  <= CFG_COL_COUNT;
        cfg_wdata <= {3'b0, cc};
        @(posedge aclk);
        chk.apply_config(CFG_COL_COUNT, {3'b0, cc});
        if (poke_unused) begin
            cfg_addr  <= CFG_UNUSED;
            cfg_wdata <= 8'h3C;
            @(posedge aclk);
            chk.apply_config(CFG_UNUSED, 8'h3C);
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Load an ascending table over the live slots
    task automatic load_ascending(bit is_row);
        logic [IDX_W:0] level;
        bit fine_steps;
        int unsigned n;
        n = chk.live_slots(is_row ? chk.row_count : chk.col_count);
        fine_steps = $urandom_range(0, 1);
        level = (IDX_W + 1)'($urandom_range(0, 20));
        for (int k = 0; k < n; k++) begin
            level = level + (fine_steps ? $urandom_range(1, 40)
                                        : $urandom_range(1, 32'hFFFF_FFFF / n));
            if (level > 33'h0_FFFF_FFFF || (k == n - 1 && $urandom_range(0, 3) == 0))
                level = 33'h0_FFFF_FFFF;
            send_load(is_row, SLOT_FW'(k), level[IDX_W-1:0], pick_owner());
        end
    endtask

    task automatic run_random(int count);
        int unsigned r, slot;
        logic [IDX_W-1:0] b;
        bit is_row;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 14) begin
                // Overwrite a slot, near its old bound or anywhere
                is_row = (r < 7);
                slot = $urandom_range(0, SLOTS - 1);
                b = (is_row ? chk.row_written[slot] : chk.col_written[slot])
                    && $urandom_range(0, 1)
                    ? (is_row ? chk.row_bound[slot] : chk.col_bound[slot])
                      + $urandom_range(0, 8) - 4
                    : $urandom;
                send_load(is_row, SLOT_FW'(slot), b, pick_owner());
            end else if (r < 18) begin
                send_clear();
            end else if (r == 18) begin
                wait_for_drain();
            end else begin
                send_classify(pick_index(1'b1), pick_index(1'b0));
            end
        end
    endtask

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        logic [LPART_W-1:0] lp;
        logic [RCNT_W-1:0] rc, cc;
        chk = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: single-range tables at reset counts
        src_gap_pct = 20;
        sink_stall_pct = 20;
        send_load(1'b1, 4'd0, 32'd100, 8'h00);
        send_load(1'b0, 4'd0, 32'd50, 8'h07);
        send_classify(32'd0, 32'd0);
        send_classify(32'd99, 32'd49);
        send_classify(32'd100, 32'd50);
        send_classify(32'hFFFF_FFFF, 32'd0);
        send_clear();
        send_classify(32'd5, 32'd5);

        // Top part id, empty column table, unused register index
        wait_for_drain();
        set_config(8'hFF, 5'd2, 5'd0, 1'b1);
        send_load(1'b1, 4'd1, 32'hFFFF_FFFF, 8'hFF);
        send_classify(32'hFFFF_FFFF, 32'd0);
        send_classify(32'hFFFF_FFFE, 32'd1);
        send_classify(32'd100, 32'hFFFF_FFFF);
        send_load(1'b0, 4'd15, 32'hFFFF_FFFF, 8'h80);

        // Counts above the table size, bound of zero in the first slot
        wait_for_drain();
        set_config(8'h80, 5'd31, 5'd17, 1'b0);
        send_classify(32'd0, 32'hFFFF_FFFE);
        send_load(1'b1, 4'd0, 32'd0, 8'h01);
        send_classify(32'd0, 32'd0);
        send_clear();

        // Random phases over a spread of settings
        for (int p = 0; p < PHASES; p++) begin
            wait_for_drain();
            case (p)
                0: begin lp = 8'h00; rc = 5'd16; cc = 5'd16; end
                1: begin lp = 8'hFF; rc = 5'd1;  cc = 5'd31; end
                2: begin lp = LPART_W'($urandom); rc = 5'd0; cc = 5'd5; end
                3: begin lp = LPART_W'($urandom); rc = 5'd8; cc = 5'd0; end
                default: begin
                    lp = LPART_W'($urandom);
                    rc = RCNT_W'($urandom_range(0, 9) == 0 ? $urandom_range(0, 31)
                                                           : $urandom_range(1, 16));
                    cc = RCNT_W'($urandom_range(0, 9) == 0 ? $urandom_range(0, 31)
                                                           : $urandom_range(1, 16));
                end
            endcase
            if (p >= PHASES - 2) begin
                src_gap_pct = 0;
                sink_stall_pct = 0;
            end else begin
                src_gap_pct = (p % 3 == 0) ? 0 : $urandom_range(5, 40);
                sink_stall_pct = (p % 3 == 1) ? 0 : $urandom_range(5, 40);
            end
            set_config(lp, rc, cc, 1'b0);
            load_ascending(1'b1);
            load_ascending(1'b0);
            run_random(RANDOM_PER_PHASE);
        end

        wait_for_drain();
        if (chk.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
